FILE: rtl/core/efd_pkg.sv
// efd_pkg: shared constants and types for the escaped frame deframer
// no dependencies; used by escaped_frame_deframer_top by scoped names
package efd_pkg;

  // field and register widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 10;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned CfgIdxW = 2;

  // upper bound on the decoded frame length
  localparam int unsigned LENGTH_LIMIT = 1023;
  localparam int unsigned CountMax     = (1 << CountW) - 1;
  localparam logic [CountW-1:0] CountCap =
    CountW'((LENGTH_LIMIT > CountMax) ? CountMax : LENGTH_LIMIT);

  // register reset values
  localparam logic [ByteW-1:0]  EscapeReset = 8'hF0;
  localparam logic [ByteW-1:0]  StartReset  = 8'hF1;
  localparam logic [ByteW-1:0]  EndReset    = 8'hF2;
  localparam logic [CountW-1:0] BufLenReset = 10'd1023;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ESCAPE  = 2'd0,
    CFG_START   = 2'd1,
    CFG_END     = 2'd2,
    CFG_BUF_LEN = 2'd3
  } cfg_idx_t;

endpackage

FILE: rtl/core/escaped_frame_deframer_top.sv
// escaped_frame_deframer_top: byte-stuffing frame decoder, one byte per transfer
// depends on efd_pkg for widths, reset values and register indexes
//
// Takes one received byte per input transfer and gives exactly one result per
// byte, registered, at one byte per clock unless the sink stalls. The decode
// decision (hunt / frame / escape) and the payload counter update sit between
// the input handshake and a single output register; in_stall rises only while
// that output register holds a result the sink is stalling. Each result carries
// either a payload byte with its index, a frame-done report with the saturating
// length and overflow flag, or neither (dropped, start and escape bytes).
// Registers: 0 escape value, 1 start value, 2 end value, 3 buffer length;
// write them only while the block is idle.
module escaped_frame_deframer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [efd_pkg::ByteW-1:0]    in_rx_byte,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_data_valid,
  output logic [efd_pkg::ByteW-1:0]    out_data_byte,
  output logic [efd_pkg::CountW-1:0]   out_data_index,
  output logic                         out_frame_done,
  output logic [efd_pkg::CountW-1:0]   out_frame_length,
  output logic                         out_overflow,
  // configuration port
  input  logic                         cfg_we,
  input  logic [efd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [efd_pkg::CfgW-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } mode_t;

  // configuration registers
  logic [efd_pkg::ByteW-1:0]  escape_value_r;
  logic [efd_pkg::ByteW-1:0]  start_value_r;
  logic [efd_pkg::ByteW-1:0]  end_value_r;
  logic [efd_pkg::CountW-1:0] buffer_length_r;

  // decoder state
  mode_t                      mode_r, mode_nxt;
  logic [efd_pkg::CountW-1:0] byte_count_r, byte_count_nxt;
  logic                       overflowed_r, overflowed_nxt;

  // output stage
  logic                       out_valid_r;
  logic                       data_valid_r, data_valid_nxt;
  logic [efd_pkg::ByteW-1:0]  data_byte_r, data_byte_nxt;
  logic [efd_pkg::CountW-1:0] data_index_r, data_index_nxt;
  logic                       frame_done_r, frame_done_nxt;
  logic [efd_pkg::CountW-1:0] frame_length_r, frame_length_nxt;
  logic                       overflow_r, overflow_nxt;

  logic                       in_xfer;
  logic                       take;
  logic [efd_pkg::ByteW-1:0]  take_byte;

  // handshake: input moves whenever the output stage is free or draining
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_value_r  <= efd_pkg::EscapeReset;
      start_value_r   <= efd_pkg::StartReset;
      end_value_r     <= efd_pkg::EndReset;
      buffer_length_r <= efd_pkg::BufLenReset;
    end else if (cfg_we) begin
      unique case (efd_pkg::cfg_idx_t'(cfg_index))
        efd_pkg::CFG_ESCAPE:  escape_value_r  <= cfg_wdata[efd_pkg::ByteW-1:0];
        efd_pkg::CFG_START:   start_value_r   <= cfg_wdata[efd_pkg::ByteW-1:0];
        efd_pkg::CFG_END:     end_value_r     <= cfg_wdata[efd_pkg::ByteW-1:0];
        efd_pkg::CFG_BUF_LEN: buffer_length_r <= cfg_wdata[efd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // per-byte decode decision
  always_comb begin
    mode_nxt         = mode_r;
    byte_count_nxt   = byte_count_r;
    overflowed_nxt   = overflowed_r;
    data_valid_nxt   = 1'b0;
    data_byte_nxt    = '0;
    data_index_nxt   = '0;
    frame_done_nxt   = 1'b0;
    frame_length_nxt = '0;
    overflow_nxt     = 1'b0;
    take             = 1'b0;
    take_byte        = in_rx_byte;

    unique case (mode_r)
      MODE_FRAME: begin
        if (in_rx_byte == end_value_r) begin
          frame_done_nxt   = 1'b1;
          frame_length_nxt = byte_count_r;
          overflow_nxt     = overflowed_r;
          mode_nxt         = MODE_HUNT;
          byte_count_nxt   = '0;
          overflowed_nxt   = 1'b0;
        end else if (in_rx_byte == escape_value_r) begin
          mode_nxt = MODE_ESC;
        end else begin
          take = 1'b1;
        end
      end
      MODE_ESC: begin
        take      = 1'b1;
        take_byte = in_rx_byte ^ escape_value_r;
        mode_nxt  = MODE_FRAME;
      end
      default: begin
        // hunting; the unused code behaves the same
        mode_nxt = MODE_HUNT;
        if (in_rx_byte == start_value_r) begin
          mode_nxt       = MODE_FRAME;
          byte_count_nxt = '0;
          overflowed_nxt = 1'b0;
        end
      end
    endcase

    // payload store with saturating count
    if (take) begin
      if (byte_count_r >= efd_pkg::CountCap) begin
        overflowed_nxt = 1'b1;
      end else begin
        if (byte_count_r < buffer_length_r) begin
          data_valid_nxt = 1'b1;
          data_byte_nxt  = take_byte;
          data_index_nxt = byte_count_r;
        end else begin
          overflowed_nxt = 1'b1;
        end
        byte_count_nxt = byte_count_r + 1'b1;
      end
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_HUNT;
      byte_count_r <= '0;
      overflowed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_r       <= mode_nxt;
        byte_count_r <= byte_count_nxt;
        overflowed_r <= overflowed_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      data_valid_r   <= data_valid_nxt;
      data_byte_r    <= data_byte_nxt;
      data_index_r   <= data_index_nxt;
      frame_done_r   <= frame_done_nxt;
      frame_length_r <= frame_length_nxt;
      overflow_r     <= overflow_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_valid   = data_valid_r;
  assign out_data_byte    = data_byte_r;
  assign out_data_index   = data_index_r;
  assign out_frame_done   = frame_done_r;
  assign out_frame_length = frame_length_r;
  assign out_overflow     = overflow_r;

  // a result never carries both a payload byte and a frame report
  a_data_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(data_valid_r && frame_done_r))
    else $error("payload byte and frame report in one result");

  // payload count never passes its cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= efd_pkg::CountCap)
    else $error("byte count above cap");

  // hunting always starts from a clean frame state
  a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HUNT |-> (byte_count_r == '0 && !overflowed_r))
    else $error("stale count while hunting");

  // closing byte inside a frame yields a frame report
  a_end_report: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && mode_r == MODE_FRAME && in_rx_byte == end_value_r)
      |=> (out_valid_r && frame_done_r && mode_r == MODE_HUNT))
    else $error("end byte did not close the frame");

endmodule

FILE: dv/tb.sv
// tb: self-checking bench for escaped_frame_deframer_top, the byte-stuffing frame decoder
// depends on efd_pkg and the deframer rtl; predicts every result and checks it field by field
// directed bytes first, then a counter-saturation frame, then random frames under many settings
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS = 700;

  typedef enum logic [1:0] {
    HUNT,
    IN_FRAME,
    AFTER_ESC
  } rx_mode_t;

  typedef struct packed {
    logic                       data_valid;
    logic [efd_pkg::ByteW-1:0]  data_byte;
    logic [efd_pkg::CountW-1:0] data_index;
    logic                       frame_done;
    logic [efd_pkg::CountW-1:0] frame_length;
    logic                       overflow;
  } deframe_result_t;

  // dut connections
  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [efd_pkg::ByteW-1:0]   in_rx_byte = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_data_valid;
  logic [efd_pkg::ByteW-1:0]   out_data_byte;
  logic [efd_pkg::CountW-1:0]  out_data_index;
  logic                        out_frame_done;
  logic [efd_pkg::CountW-1:0]  out_frame_length;
  logic                        out_overflow;
  logic                        cfg_we = 1'b0;
  logic [efd_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [efd_pkg::CfgW-1:0]    cfg_wdata = '0;

  escaped_frame_deframer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_valid   (out_data_valid),
    .out_data_byte    (out_data_byte),
    .out_data_index   (out_data_index),
    .out_frame_done   (out_frame_done),
    .out_frame_length (out_frame_length),
    .out_overflow     (out_overflow),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder shadow: registers and frame state as the block should hold them
  logic [efd_pkg::ByteW-1:0]  esc_val   = efd_pkg::EscapeReset;
  logic [efd_pkg::ByteW-1:0]  start_val = efd_pkg::StartReset;
  logic [efd_pkg::ByteW-1:0]  end_val   = efd_pkg::EndReset;
  logic [efd_pkg::CountW-1:0] buf_len   = efd_pkg::BufLenReset;
  rx_mode_t                   rx_mode   = HUNT;
  logic [efd_pkg::CountW-1:0] byte_cnt  = '0;
  logic                       ovf_flag  = 1'b0;

  // register values the stimulus is currently built for
  logic [efd_pkg::ByteW-1:0]  tx_esc   = efd_pkg::EscapeReset;
  logic [efd_pkg::ByteW-1:0]  tx_start = efd_pkg::StartReset;
  logic [efd_pkg::ByteW-1:0]  tx_end   = efd_pkg::EndReset;
  logic [efd_pkg::CountW-1:0] tx_buf   = efd_pkg::BufLenReset;

  logic [efd_pkg::ByteW-1:0] rx_byte_q [$];
  deframe_result_t  decoded_q [$];
  int unsigned      bytes_pending = 0;
  int unsigned      bytes_queued  = 0;
  int unsigned      mismatches    = 0;
  int unsigned      idle_cycles   = 0;
  int unsigned      in_gap        = 0;
  int unsigned      out_gap       = 0;
  bit               in_taken      = 1'b0;
  bit               in_quiet      = 1'b0;
  bit               out_quiet     = 1'b0;

  function automatic int unsigned idle_len(bit quiet);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // payload byte: stored if below the buffer length, dropped at the counter cap
  function automatic void store_payload(logic [efd_pkg::ByteW-1:0] b,
                                        inout deframe_result_t r);
    if (byte_cnt >= efd_pkg::CountCap) begin
      ovf_flag = 1'b1;
    end else begin
      if (byte_cnt < buf_len) begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        r.data_index = byte_cnt;
      end else begin
        ovf_flag = 1'b1;
      end
      byte_cnt++;
    end
  endfunction

  // one received byte in, one result out
  function automatic deframe_result_t decode_byte(logic [efd_pkg::ByteW-1:0] b);
    deframe_result_t r;
    r = '0;
    case (rx_mode)
      IN_FRAME: begin
        // end check wins over the escape check
        if (b == end_val) begin
          r.frame_done   = 1'b1;
          r.frame_length = byte_cnt;
          r.overflow     = ovf_flag;
          rx_mode  = HUNT;
          byte_cnt = '0;
          ovf_flag = 1'b0;
        end else if (b == esc_val) begin
          rx_mode = AFTER_ESC;
        end else begin
          store_payload(b, r);
        end
      end
      AFTER_ESC: begin
        store_payload(b ^ esc_val, r);
        rx_mode = IN_FRAME;
      end
      default: begin
        if (b == start_val) begin
          rx_mode  = IN_FRAME;
          byte_cnt = '0;
          ovf_flag = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void apply_write(efd_pkg::cfg_idx_t idx, logic [efd_pkg::CfgW-1:0] v);
    case (idx)
      efd_pkg::CFG_ESCAPE:  esc_val   = v[efd_pkg::ByteW-1:0];
      efd_pkg::CFG_START:   start_val = v[efd_pkg::ByteW-1:0];
      efd_pkg::CFG_END:     end_val   = v[efd_pkg::ByteW-1:0];
      efd_pkg::CFG_BUF_LEN: buf_len   = v[efd_pkg::CountW-1:0];
      default: ;
    endcase
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result(deframe_result_t want);
    if (out_data_valid !== want.data_valid)
      flag_error($sformatf("data_valid got %b want %b", out_data_valid, want.data_valid));
    if (out_data_byte !== want.data_byte)
      flag_error($sformatf("data_byte got %h want %h", out_data_byte, want.data_byte));
    if (out_data_index !== want.data_index)
      flag_error($sformatf("data_index got %0d want %0d", out_data_index, want.data_index));
    if (out_frame_done !== want.frame_done)
      flag_error($sformatf("frame_done got %b want %b", out_frame_done, want.frame_done));
    if (out_frame_length !== want.frame_length)
      flag_error($sformatf("frame_length got %0d want %0d", out_frame_length,
                           want.frame_length));
    if (out_overflow !== want.overflow)
      flag_error($sformatf("overflow got %b want %b", out_overflow, want.overflow));
  endtask

  // sample both channels and the config port, predict and check, watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken    = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (cfg_we) apply_write(efd_pkg::cfg_idx_t'(cfg_index), cfg_wdata);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) flag_error("result transfer with nothing expected");
        else check_result(decoded_q.pop_front());
      end
      if (in_taken) begin
        decoded_q.push_back(decode_byte(in_rx_byte));
        bytes_pending--;
      end
      if (in_taken || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // input driver: next byte after each transfer, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (rx_byte_q.size() > 0) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_byte_q.pop_front();
        in_gap = idle_len(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      out_gap = idle_len(out_quiet);
    end
  end

  task automatic push_byte(logic [efd_pkg::ByteW-1:0] b);
    rx_byte_q.push_back(b);
    bytes_pending++;
    bytes_queued++;
  endtask

  // bytes between frames; a start byte here would open a frame
  task automatic push_noise(int unsigned n, bit allow_start);
    logic [efd_pkg::ByteW-1:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0:       b = tx_end;
        1:       b = tx_esc;
        default: b = efd_pkg::ByteW'($urandom_range(0, 255));
      endcase
      if (!allow_start && b == tx_start) b = b ^ 8'h01;
      push_byte(b);
    end
  endtask

  // start byte, len payload bytes with escapes where needed, optional end byte
  task automatic push_frame(int unsigned len, bit close);
    logic [efd_pkg::ByteW-1:0] b;
    push_byte(tx_start);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = tx_start;
        1:       b = tx_end;
        2:       b = tx_esc;
        default: b = efd_pkg::ByteW'($urandom_range(0, 255));
      endcase
      if (b == tx_end || b == tx_esc || $urandom_range(0, 11) == 0) begin
        push_byte(tx_esc);
        push_byte(b ^ tx_esc);
      end else begin
        push_byte(b);
      end
    end
    // escaped closing byte right before the real one
    if ($urandom_range(0, 7) == 0) begin
      push_byte(tx_esc);
      push_byte(tx_end);
    end
    if (close) push_byte(tx_end);
  endtask

  // wait until every byte is taken and every result has come back
  task automatic drain_pipeline();
    do @(negedge clk);
    while (bytes_pending != 0 || decoded_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // write all four registers; presets first, random settings after
  task automatic configure(int unsigned phase);
    logic [efd_pkg::CfgW-1:0] v [4];
    case (phase)
      0: v = '{10'h000, 10'h0FF, 10'h080, 10'd1023};
      1: v = '{10'h0FF, 10'h000, 10'h001, 10'd0};
      2: v = '{10'h010, 10'h020, 10'h010, 10'd4};   // escape equals end
      3: v = '{10'h033, 10'h055, 10'h055, 10'd7};   // start equals end
      4: v = '{10'h055, 10'h055, 10'h066, 10'd3};   // start equals escape
      5: v = '{10'h0F0, 10'h0F1, 10'h0F2, 10'd1};
      default: begin
        v[0] = efd_pkg::CfgW'($urandom_range(0, 255));
        v[1] = efd_pkg::CfgW'($urandom_range(0, 255));
        v[2] = efd_pkg::CfgW'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
          0: v[2] = v[0];
          1: v[1] = v[2];
          2: v[1] = v[0];
          default: ;
        endcase
        case ($urandom_range(0, 19))
          0:       v[3] = '0;
          1, 2, 3: v[3] = 10'd1023;
          4:       v[3] = efd_pkg::CfgW'($urandom_range(13, 1023));
          default: v[3] = efd_pkg::CfgW'($urandom_range(1, 12));
        endcase
      end
    endcase
    tx_esc   = v[0][efd_pkg::ByteW-1:0];
    tx_start = v[1][efd_pkg::ByteW-1:0];
    tx_end   = v[2][efd_pkg::ByteW-1:0];
    tx_buf   = v[3][efd_pkg::CountW-1:0];
    // byte registers get junk in the upper bits, which must be masked off
    for (int unsigned i = 0; i < 3; i++)
      v[i][efd_pkg::CfgW-1:efd_pkg::ByteW] = 2'($urandom_range(0, 3));
    for (int unsigned i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= efd_pkg::cfg_idx_t'(i);
      cfg_wdata <= v[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus sequencing
  initial begin
    int unsigned phase;
    int unsigned random_base;
    int unsigned phase_base;
    int unsigned max_len;
    int unsigned roll;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed bytes under the reset settings
    @(posedge clk);
    push_byte(8'h00); push_byte(8'hFF);            // dropped while hunting
    push_byte(efd_pkg::EndReset);                  // end and escape ignored while hunting
    push_byte(efd_pkg::EscapeReset);
    push_byte(efd_pkg::StartReset);
    push_byte(8'h00); push_byte(8'hFF);
    push_byte(efd_pkg::StartReset);                // start inside a frame is payload
    push_byte(efd_pkg::EscapeReset); push_byte(efd_pkg::EndReset);   // escaped end byte
    push_byte(efd_pkg::EscapeReset); push_byte(efd_pkg::EscapeReset);
    push_byte(efd_pkg::EscapeReset); push_byte(efd_pkg::StartReset);
    push_byte(efd_pkg::EscapeReset); push_byte(8'h0F);
    push_byte(efd_pkg::EndReset);
    push_byte(efd_pkg::StartReset); push_byte(efd_pkg::EndReset);    // empty frame
    push_byte(efd_pkg::StartReset); push_byte(8'hAA); push_byte(efd_pkg::EndReset);
    drain_pipeline();

    // counter saturation: more payload bytes than the counter can hold
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    @(posedge clk);
    push_frame(int'(efd_pkg::CountCap) + 3, 1'b1);
    drain_pipeline();

    // random frames, one setting per phase, idle until drained between phases
    random_base = bytes_queued;
    phase = 0;
    while (bytes_queued - random_base < RANDOM_ITEMS) begin
      configure(phase);
      phase++;
      @(posedge clk);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      phase_base = bytes_queued;
      max_len = (tx_buf < 14) ? int'(tx_buf) + 3 : 16;
      while (bytes_queued - phase_base < 80) begin
        roll = $urandom_range(0, 9);
        if (roll < 8) begin
          push_noise($urandom_range(0, 2), 1'b0);
          push_frame($urandom_range(0, max_len), 1'b1);
        end else if (roll == 8) begin
          push_frame($urandom_range(0, max_len), 1'b0);   // left open
        end else begin
          push_noise($urandom_range(1, 6), 1'b1);
        end
      end
      drain_pipeline();
    end

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
